// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is not checked while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mrd_pkg.sv =====
// ----------------------------------------------------------------------------
// MQTT receive deframer package
// Shared result type, byte class codes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mrd_pkg;

  localparam int BYTE_W = 8;
  localparam int CLASS_W = 3;
  localparam int NIB_W = 4;
  localparam int LEN_W = 28;
  localparam int TOPIC_W = 16;

  // Byte class codes.
  localparam logic [CLASS_W-1:0] CLS_TYPE = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_LENGTH = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_TOPIC_LEN = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_TOPIC = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_PAYLOAD = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_OTHER = 3'd5;

  // Control packet type of a PUBLISH.
  localparam logic [NIB_W-1:0] TYPE_PUBLISH = 4'h3;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic [CLASS_W-1:0] byte_class;
    logic [NIB_W-1:0]   ctrl_type;
    logic [NIB_W-1:0]   packet_flags;
    logic [LEN_W-1:0]   remaining_length;
    logic               last_of_packet;
    logic               message_dropped;
  } result_t;

endpackage

`default_nettype wire

// ===== src/mrd_parse.sv =====
// ----------------------------------------------------------------------------
// MQTT deframer parse stage
// Packet state registers and the per-byte tagging logic.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mrd_parse
  import mrd_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output result_t                res
);

  localparam int IDX_W = (MAX_LENGTH_BYTES > 1) ? $clog2(MAX_LENGTH_BYTES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LENGTH_BYTES - 1);

  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  logic [1:0]         phase_r, phase_nxt;
  logic [BYTE_W-1:0]  header_r, header_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [LEN_W-1:0]   body_r, body_nxt;
  logic [TOPIC_W-1:0] topic_r, topic_nxt;
  logic               drop_r, drop_nxt;

  logic               is_pub;
  logic [4:0]         shift;
  logic [LEN_W-1:0]   len_sum;
  logic [LEN_W-1:0]   body_inc;
  logic [TOPIC_W-1:0] topic_new;
  logic [TOPIC_W:0]   topic_end_new;
  logic [TOPIC_W:0]   topic_end;
  logic [CLASS_W-1:0] cls;
  logic               last;
  logic               dropped;

  assign is_pub = (header_r[7:4] == TYPE_PUBLISH);
  assign shift = 5'(idx_r) * 5'd7;
  assign len_sum = len_r + (LEN_W'(rx_byte[6:0]) << shift);
  assign body_inc = body_r + LEN_W'(1);
  assign topic_new = {topic_r[15:8], rx_byte};
  assign topic_end_new = {1'b0, topic_new} + 17'd2;
  assign topic_end = {1'b0, topic_r} + 17'd2;

  always_comb begin
    phase_nxt = phase_r;
    header_nxt = header_r;
    len_nxt = len_r;
    idx_nxt = idx_r;
    body_nxt = body_r;
    topic_nxt = topic_r;
    drop_nxt = drop_r;
    cls = CLS_OTHER;
    last = 1'b0;
    dropped = 1'b0;
    case (phase_r)
      PH_LEN: begin
        cls = CLS_LENGTH;
        len_nxt = len_sum;
        if (!rx_byte[7] || idx_r >= IDX_LAST) begin
          idx_nxt = '0;
          if (len_sum == '0) begin
            last = 1'b1;
            dropped = is_pub;
            phase_nxt = PH_TYPE;
          end else begin
            phase_nxt = PH_BODY;
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      PH_BODY: begin
        if (is_pub) begin
          if (body_r == '0) begin
            cls = CLS_TOPIC_LEN;
            topic_nxt = {rx_byte, 8'h00};
          end else if (body_r == LEN_W'(1)) begin
            cls = CLS_TOPIC_LEN;
            topic_nxt = topic_new;
            if (LEN_W'(topic_end_new) > len_r) begin
              drop_nxt = 1'b1;
            end
          end else if (drop_r) begin
            cls = CLS_OTHER;
          end else if (body_r < LEN_W'(topic_end)) begin
            cls = CLS_TOPIC;
          end else begin
            cls = CLS_PAYLOAD;
          end
        end
        body_nxt = body_inc;
        if (body_inc >= len_r) begin
          last = 1'b1;
          dropped = is_pub && ((len_r < LEN_W'(2)) || drop_nxt);
          phase_nxt = PH_TYPE;
        end
      end
      default: begin
        cls = CLS_TYPE;
        header_nxt = rx_byte;
        len_nxt = '0;
        idx_nxt = '0;
        body_nxt = '0;
        topic_nxt = '0;
        drop_nxt = 1'b0;
        phase_nxt = PH_LEN;
      end
    endcase
  end

  always_comb begin
    res.data_byte = rx_byte;
    res.byte_class = cls;
    res.ctrl_type = header_nxt[7:4];
    res.packet_flags = header_nxt[3:0];
    res.remaining_length = len_nxt;
    res.last_of_packet = last;
    res.message_dropped = dropped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      header_r <= '0;
      len_r <= '0;
      idx_r <= '0;
      body_r <= '0;
      topic_r <= '0;
      drop_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      header_r <= header_nxt;
      len_r <= len_nxt;
      idx_r <= idx_nxt;
      body_r <= body_nxt;
      topic_r <= topic_nxt;
      drop_r <= drop_nxt;
    end
  end

  `ASSERT_CLK(a_drop_needs_last, clk, rst_n, step && dropped |-> last, "drop off last byte")
  `ASSERT_CLK(a_drop_only_pub, clk, rst_n, step && dropped |-> is_pub, "drop on non-publish")
  `ASSERT_CLK(a_last_ends, clk, rst_n, step && last |=> phase_r == PH_TYPE, "no restart")
  `ASSERT_CLK(a_type_len, clk, rst_n, step && phase_r == PH_TYPE |=> phase_r == PH_LEN, "no len")

endmodule

`default_nettype wire

// ===== src/mqtt_receive_deframer.sv =====
// ----------------------------------------------------------------------------
// MQTT receive deframer
// Tags every received byte of an MQTT control packet stream.
// ----------------------------------------------------------------------------
// The block takes one received byte per transfer on the in_ channel and gives
// exactly one tagged result per byte on the out_ channel. It sustains one
// transfer per clock cycle on both sides while the out_ channel is not stalled.
// A byte accepted on the in_ channel waits in the input register, passes the
// single parse stage and lands in the result register, from which it is
// offered on the out_ channel; a stall on the out_ channel holds it back in
// the input register. Each result carries the byte itself, its class (type
// byte, remaining-length byte, topic-length byte, topic, payload or other body
// byte), the type and flags nibbles of the packet it belongs to, the remaining
// length decoded so far, a flag on the packet's last byte, and a drop flag on
// the last byte of a PUBLISH that cannot be split into topic and payload. The
// remaining length takes at most MAX_LENGTH_BYTES bytes; the last of those
// ends the field whatever its continuation bit.
`default_nettype none

module mqtt_receive_deframer
  import mrd_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [BYTE_W-1:0]  in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [BYTE_W-1:0]       out_data_byte,
  output logic [CLASS_W-1:0]      out_byte_class,
  output logic [NIB_W-1:0]        out_ctrl_type,
  output logic [NIB_W-1:0]        out_packet_flags,
  output logic [LEN_W-1:0]        out_remaining_length,
  output logic                    out_last_of_packet,
  output logic                    out_message_dropped
);

  // Input register: holds one accepted byte until the parse stage takes it.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;

  // Result register.
  logic    out_valid_r;
  result_t out_res_r;
  result_t parse_res;

  // The parse stage advances when it has a byte and the result register is
  // empty or being emptied by a transfer in this same cycle.
  logic advance;

  assign advance = s1_valid_r && (!out_valid_r || out_ready);
  // No input is taken while reset is held.
  assign in_ready = rst_n && (!s1_valid_r || advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  mrd_parse #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .rx_byte(s1_byte_r),
    .res    (parse_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= parse_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data_byte = out_res_r.data_byte;
  assign out_byte_class = out_res_r.byte_class;
  assign out_ctrl_type = out_res_r.ctrl_type;
  assign out_packet_flags = out_res_r.packet_flags;
  assign out_remaining_length = out_res_r.remaining_length;
  assign out_last_of_packet = out_res_r.last_of_packet;
  assign out_message_dropped = out_res_r.message_dropped;

endmodule

`default_nettype wire

// ===== tb/tb_mqtt_receive_deframer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MQTT receive deframer testbench
// Drives a stream of MQTT control packets byte by byte through the deframer.
// Each byte's tag is checked field by field against a built-in parser that
// tracks the same framing state. A short table of hand-picked packets comes
// first, followed by randomly built packets with random idling on both sides.
// ----------------------------------------------------------------------------

module tb_mqtt_receive_deframer
  import mrd_pkg::*;
();

  localparam int MAX_LEN_BYTES  = 4;
  localparam int ITEM_TARGET    = 1150;
  localparam int HOLD_AT        = 350;
  localparam int DRAIN_AT       = 750;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;
  localparam int DIR_N          = 25;

  localparam result_t NO_TAG = '0;

  // One row of the directed table: the byte to send, and optionally a tag that
  // is written out by hand instead of taken from the parser.
  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              typed;
    result_t           tag;
  } dir_row_t;

  typedef enum logic [1:0] {
    AWAIT_TYPE,
    IN_LENGTH,
    IN_BODY
  } parse_state_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_rx_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_data_byte;
  logic [CLASS_W-1:0]  out_byte_class;
  logic [NIB_W-1:0]    out_ctrl_type;
  logic [NIB_W-1:0]    out_packet_flags;
  logic [LEN_W-1:0]    out_remaining_length;
  logic                out_last_of_packet;
  logic                out_message_dropped;

  mqtt_receive_deframer #(
    .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data_byte       (out_data_byte),
    .out_byte_class      (out_byte_class),
    .out_ctrl_type       (out_ctrl_type),
    .out_packet_flags    (out_packet_flags),
    .out_remaining_length(out_remaining_length),
    .out_last_of_packet  (out_last_of_packet),
    .out_message_dropped (out_message_dropped)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Tags still owed by the block, oldest first.
  result_t expected_tags[$];
  result_t want;
  int      errors = 0;
  int      bytes_sent = 0;
  int      burst_left = 0;
  int      quiet_cycles = 0;
  logic    hold_req = 1'b0;

  // Framing state of the parser that predicts the tags.
  parse_state_e        parse_state = AWAIT_TYPE;
  logic [BYTE_W-1:0]   hdr_byte = '0;
  logic [LEN_W-1:0]    len_total = '0;
  logic [1:0]          len_idx = '0;
  logic [LEN_W-1:0]    body_cnt = '0;
  logic [TOPIC_W-1:0]  topic_len = '0;
  logic                drop_flag = 1'b0;

  // Works out the tag of one received byte and advances the framing state.
  function automatic result_t tag_byte(input logic [BYTE_W-1:0] b);
    result_t            r;
    logic [CLASS_W-1:0] cls;
    logic               last;
    logic               dropped;
    logic               is_pub;
    logic [LEN_W-1:0]   pos;
    cls     = CLS_OTHER;
    last    = 1'b0;
    dropped = 1'b0;
    is_pub  = (hdr_byte[7:4] == TYPE_PUBLISH);
    case (parse_state)
      IN_LENGTH: begin
        cls = CLS_LENGTH;
        len_total = len_total + (LEN_W'(b[6:0]) << (7 * int'(len_idx)));
        // The last allowed length byte closes the field even with its
        // continuation bit set.
        if (!b[7] || int'(len_idx) >= MAX_LEN_BYTES - 1) begin
          len_idx = '0;
          if (len_total == '0) begin
            last = 1'b1;
            dropped = is_pub;
            parse_state = AWAIT_TYPE;
          end else begin
            parse_state = IN_BODY;
          end
        end else begin
          len_idx = len_idx + 2'd1;
        end
      end
      IN_BODY: begin
        pos = body_cnt;
        if (is_pub) begin
          if (pos == '0) begin
            cls = CLS_TOPIC_LEN;
            topic_len = {b, 8'h00};
          end else if (pos == LEN_W'(1)) begin
            cls = CLS_TOPIC_LEN;
            topic_len[7:0] = b;
            if (int'(topic_len) + 2 > int'(len_total)) begin
              drop_flag = 1'b1;
            end
          end else if (drop_flag) begin
            cls = CLS_OTHER;
          end else if (int'(pos) < int'(topic_len) + 2) begin
            cls = CLS_TOPIC;
          end else begin
            cls = CLS_PAYLOAD;
          end
        end
        body_cnt = pos + LEN_W'(1);
        if (body_cnt >= len_total) begin
          last = 1'b1;
          if (is_pub && (len_total < LEN_W'(2) || drop_flag)) begin
            dropped = 1'b1;
          end
          parse_state = AWAIT_TYPE;
        end
      end
      default: begin
        cls = CLS_TYPE;
        hdr_byte = b;
        len_total = '0;
        len_idx = '0;
        body_cnt = '0;
        topic_len = '0;
        drop_flag = 1'b0;
        parse_state = IN_LENGTH;
      end
    endcase
    r.data_byte        = b;
    r.byte_class       = cls;
    r.ctrl_type        = hdr_byte[7:4];
    r.packet_flags     = hdr_byte[3:0];
    r.remaining_length = len_total;
    r.last_of_packet   = last;
    r.message_dropped  = dropped;
    return r;
  endfunction

  // Offers one byte and waits for its transfer. The sender runs in bursts; at
  // the start of each burst valid is dropped for a random pause. Once the byte
  // is taken, its tag is queued: the hand-written one if the table gives it,
  // the parser's otherwise. The parser always runs so its state stays in step.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                           input result_t typed_tag);
    result_t predicted;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 250)
                                               : $urandom_range(1, 20);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = tag_byte(b);
    expected_tags.insert(expected_tags.size(), typed ? typed_tag : predicted);
    bytes_sent++;
  endtask

  // Compares the tag on the output ports with the one that was expected.
  task automatic check_tag(input result_t exp);
    if (out_data_byte !== exp.data_byte) begin
      $error("data_byte: expected %0h, got %0h", exp.data_byte, out_data_byte);
      errors++;
    end
    if (out_byte_class !== exp.byte_class) begin
      $error("byte_class: expected %0d, got %0d", exp.byte_class, out_byte_class);
      errors++;
    end
    if (out_ctrl_type !== exp.ctrl_type) begin
      $error("ctrl_type: expected %0h, got %0h", exp.ctrl_type, out_ctrl_type);
      errors++;
    end
    if (out_packet_flags !== exp.packet_flags) begin
      $error("packet_flags: expected %0h, got %0h", exp.packet_flags, out_packet_flags);
      errors++;
    end
    if (out_remaining_length !== exp.remaining_length) begin
      $error("remaining_length: expected %0d, got %0d", exp.remaining_length,
             out_remaining_length);
      errors++;
    end
    if (out_last_of_packet !== exp.last_of_packet) begin
      $error("last_of_packet: expected %0b, got %0b", exp.last_of_packet,
             out_last_of_packet);
      errors++;
    end
    if (out_message_dropped !== exp.message_dropped) begin
      $error("message_dropped: expected %0b, got %0b", exp.message_dropped,
             out_message_dropped);
      errors++;
    end
  endtask

  // Result side: every output transfer must match the oldest owed tag. The
  // values read here are the ones that stood before this clock edge, which is
  // what the block itself saw.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_tags.size() == 0) begin
        $error("result transfer with no tag owed: data_byte %0h", out_data_byte);
        errors++;
      end else begin
        want = expected_tags.pop_front();
        check_tag(want);
      end
    end
  end

  // Watchdog: a long stretch with no transfer on either side means the block
  // has hung. The limit is several times the longest stall the test creates.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** mqtt_receive_deframer: FAILED **");
      $finish;
    end
  end

  // Receiver: picks a stall pattern for a window of cycles at a time. It is
  // either always ready, follows a rotating bit mask, or stalls at random.
  // When asked, it holds off for a long stretch counted here, so that the
  // block fills up and pushes back on the sender.
  initial begin : receiver
    int               win;
    int               mode;
    logic [7:0]       mask;
    win  = 0;
    mode = 0;
    mask = 8'hff;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (win == 0) begin
          mode = $urandom_range(0, 2);
          mask = 8'($urandom);
          win  = $urandom_range(16, 96);
        end
        win--;
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= mask[0];
            mask = {mask[0], mask[7:1]};
          end
          default: begin
            out_ready <= ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  // Sender and run control.
  initial begin : stimulus
    dir_row_t          dir_rows[DIR_N];
    logic [BYTE_W-1:0] pkt[$];
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] grp;
    logic [TOPIC_W-1:0] tl;
    logic              framed;
    logic              pad;
    logic              hold_done;
    logic              drain_done;
    int                kind;
    int                body_len;
    int                pay_len;
    int                v;
    int                n;
    int                pad_len;
    int                i;
    int                k;

    // Directed packets. Hand-written tags cover the states right after reset,
    // zero-length packets, the short PUBLISH, the topic overrun and the
    // overlong length field; the other rows go through the parser.
    // Type byte zero with a zero remaining length.
    dir_rows[0]  = {8'h00, 1'b1, 8'h00, CLS_TYPE, 4'h0, 4'h0, 28'd0, 1'b0, 1'b0};
    dir_rows[1]  = {8'h00, 1'b1, 8'h00, CLS_LENGTH, 4'h0, 4'h0, 28'd0, 1'b1, 1'b0};
    // PUBLISH with zero remaining length: ends on the length byte and drops.
    dir_rows[2]  = {8'h3f, 1'b1, 8'h3f, CLS_TYPE, 4'h3, 4'hf, 28'd0, 1'b0, 1'b0};
    dir_rows[3]  = {8'h00, 1'b1, 8'h00, CLS_LENGTH, 4'h3, 4'hf, 28'd0, 1'b1, 1'b1};
    // PUBLISH with a one-byte body: that byte is a topic-length byte, dropped.
    dir_rows[4]  = {8'h30, 1'b0, NO_TAG};
    dir_rows[5]  = {8'h01, 1'b0, NO_TAG};
    dir_rows[6]  = {8'hff, 1'b1, 8'hff, CLS_TOPIC_LEN, 4'h3, 4'h0, 28'd1, 1'b1, 1'b1};
    // Well-formed PUBLISH: one topic byte, one payload byte.
    dir_rows[7]  = {8'h30, 1'b0, NO_TAG};
    dir_rows[8]  = {8'h04, 1'b0, NO_TAG};
    dir_rows[9]  = {8'h00, 1'b0, NO_TAG};
    dir_rows[10] = {8'h01, 1'b0, NO_TAG};
    dir_rows[11] = {8'h41, 1'b0, NO_TAG};
    dir_rows[12] = {8'h42, 1'b0, NO_TAG};
    // PUBLISH whose topic length overruns the body.
    dir_rows[13] = {8'h31, 1'b0, NO_TAG};
    dir_rows[14] = {8'h03, 1'b0, NO_TAG};
    dir_rows[15] = {8'hff, 1'b0, NO_TAG};
    dir_rows[16] = {8'hff, 1'b0, NO_TAG};
    dir_rows[17] = {8'h00, 1'b1, 8'h00, CLS_OTHER, 4'h3, 4'h1, 28'd3, 1'b1, 1'b1};
    // Non-publish packet with an overlong length field: the fourth length
    // byte still has its continuation bit set and closes the field anyway.
    dir_rows[18] = {8'he0, 1'b0, NO_TAG};
    dir_rows[19] = {8'h82, 1'b0, NO_TAG};
    dir_rows[20] = {8'h80, 1'b0, NO_TAG};
    dir_rows[21] = {8'h80, 1'b0, NO_TAG};
    dir_rows[22] = {8'h80, 1'b1, 8'h80, CLS_LENGTH, 4'he, 4'h0, 28'd2, 1'b0, 1'b0};
    dir_rows[23] = {8'hff, 1'b0, NO_TAG};
    dir_rows[24] = {8'h7f, 1'b1, 8'h7f, CLS_OTHER, 4'he, 4'h0, 28'd2, 1'b1, 1'b0};

    hold_done  = 1'b0;
    drain_done = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_N; i++) begin
      send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].tag);
    end

    // Random packets. Most are well-formed PUBLISH packets with random topic
    // and payload; the rest are other packet types, broken PUBLISH packets
    // and random headers. Some length fields carry redundant zero groups, up
    // to the full four bytes.
    while (bytes_sent < ITEM_TARGET) begin
      pkt.delete();
      kind   = $urandom_range(0, 99);
      pad    = ($urandom_range(0, 6) == 0);
      framed = 1'b0;
      tl     = 16'($urandom);
      if (kind < 60) begin
        hdr      = {TYPE_PUBLISH, 4'($urandom)};
        tl       = 16'($urandom_range(0, 6));
        pay_len  = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 260)
                                               : $urandom_range(0, 10);
        body_len = 2 + int'(tl) + pay_len;
        framed   = 1'b1;
      end else if (kind < 75) begin
        hdr = 8'($urandom);
        while (hdr[7:4] == TYPE_PUBLISH) hdr = 8'($urandom);
        body_len = $urandom_range(0, 12);
      end else if (kind < 90) begin
        hdr      = {TYPE_PUBLISH, 4'($urandom)};
        body_len = $urandom_range(0, 6);
        // Either just one byte too long for the body, or anything at all.
        if ($urandom_range(0, 1) == 1) tl = 16'(body_len - 1);
        framed   = 1'b1;
      end else begin
        hdr      = 8'($urandom);
        body_len = $urandom_range(0, 4);
      end

      pkt.insert(pkt.size(), hdr);
      v = body_len;
      n = 0;
      do begin
        grp = {1'b0, 7'(v)};
        v = v >> 7;
        n++;
        if (v != 0 || (pad && n < MAX_LEN_BYTES)) grp[7] = 1'b1;
        pkt.insert(pkt.size(), grp);
      end while (v != 0);
      if (pad && n < MAX_LEN_BYTES) begin
        pad_len = $urandom_range(1, MAX_LEN_BYTES - n);
        for (k = 1; k <= pad_len; k++) begin
          n++;
          if (k < pad_len) begin
            pkt.insert(pkt.size(), 8'h80);
          end else if (n == MAX_LEN_BYTES) begin
            pkt.insert(pkt.size(), {1'($urandom), 7'h00});
          end else begin
            pkt.insert(pkt.size(), 8'h00);
          end
        end
      end
      for (k = 0; k < body_len; k++) begin
        if (framed && k == 0) begin
          pkt.insert(pkt.size(), tl[15:8]);
        end else if (framed && k == 1) begin
          pkt.insert(pkt.size(), tl[7:0]);
        end else begin
          pkt.insert(pkt.size(), 8'($urandom));
        end
      end

      foreach (pkt[j]) send_byte(pkt[j], 1'b0, NO_TAG);

      // Long receiver hold-off while the sender keeps offering bytes.
      if (!hold_done && bytes_sent >= HOLD_AT) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      // Sender pause until every owed tag has come back.
      if (!drain_done && bytes_sent >= DRAIN_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_tags.size() != 0) @(posedge clk);
        drain_done = 1'b1;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tags.size() != 0) @(posedge clk);
    // Keep the clock running to catch any stray result transfer.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** mqtt_receive_deframer: PASSED **");
    end else begin
      $display("** mqtt_receive_deframer: FAILED **");
    end
    $finish;
  end

endmodule
